### sv/tbpr_pkg.sv
// Shared types, constants and a helper function of the tile background pixel renderer.
package tbpr_pkg;

    // Video memory: 8 KiB seen as two banks of 4 KiB, even bytes and odd bytes
    localparam int VRAM_AW    = 13;
    localparam int BANK_AW    = 12;
    localparam int BANK_DEPTH = 4096;
    localparam int CFG_IW     = 3;

    // Item codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] REG_LCD_CONTROL = 3'd0;
    localparam logic [CFG_IW-1:0] REG_SCROLL_Y    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_SCROLL_X    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_WINDOW_Y    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_WINDOW_X    = 3'd4;
    localparam logic [CFG_IW-1:0] REG_BG_PALETTE  = 3'd5;

    // Reset values
    localparam logic [7:0] LCDC_RESET    = 8'd145;
    localparam logic [7:0] PALETTE_RESET = 8'd252;

    // Control byte bit positions
    localparam int LCDC_BG_MAP_HI  = 3;
    localparam int LCDC_TILES_UNS  = 4;
    localparam int LCDC_WIN_ON     = 5;
    localparam int LCDC_WIN_MAP_HI = 6;

    // Grey levels of the four shades
    localparam logic [7:0] GREY_0 = 8'hFF;
    localparam logic [7:0] GREY_1 = 8'hAA;
    localparam logic [7:0] GREY_2 = 8'h55;
    localparam logic [7:0] GREY_3 = 8'h00;

    // Signed tile numbers sit around the middle of the tile area
    localparam logic [8:0] SIGNED_TILE_BASE = 9'h080;

    typedef struct packed {
        logic [7:0] lcd_control;
        logic [7:0] scroll_y;
        logic [7:0] scroll_x;
        logic [7:0] window_y;
        logic [7:0] window_x;
        logic [7:0] bg_palette;
    } cfg_regs_t;

    // Map a 2-bit colour through the palette and return the grey level
    function automatic logic [7:0] grey_of(input logic [7:0] palette, input logic [1:0] colour);
        logic [1:0] shade;
        logic [7:0] grey;
        begin
            unique case (colour)
                2'd0: shade = palette[1:0];
                2'd1: shade = palette[3:2];
                2'd2: shade = palette[5:4];
                default: shade = palette[7:6];
            endcase
            unique case (shade)
                2'd0: grey = GREY_0;
                2'd1: grey = GREY_1;
                2'd2: grey = GREY_2;
                default: grey = GREY_3;
            endcase
            return grey;
        end
    endfunction

endpackage

### sv/tbpr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tbpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/tbpr_cfg_regs.sv
// Configuration register file of the tile background pixel renderer.
module tbpr_cfg_regs
    import tbpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [CFG_IW-1:0] wr_index,
    input  logic [7:0]        wr_data,
    output cfg_regs_t         cfg
);

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_LCD_CONTROL: cfg_next.lcd_control = wr_data;
                REG_SCROLL_Y:    cfg_next.scroll_y    = wr_data;
                REG_SCROLL_X:    cfg_next.scroll_x    = wr_data;
                REG_WINDOW_Y:    cfg_next.window_y    = wr_data;
                REG_WINDOW_X:    cfg_next.window_x    = wr_data;
                REG_BG_PALETTE:  cfg_next.bg_palette  = wr_data;
                default:         cfg_next = cfg_reg;  // drop writes beyond the list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lcd_control <= LCDC_RESET;
            cfg_reg.scroll_y    <= '0;
            cfg_reg.scroll_x    <= '0;
            cfg_reg.window_y    <= '0;
            cfg_reg.window_x    <= '0;
            cfg_reg.bg_palette  <= PALETTE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/tile_background_pixel_renderer_top.sv
// Top level of the tile background pixel renderer: video memory, fetch sequencer, output register.
//
// The block holds 8 KiB of video memory in two 4 KiB banks (even and odd bytes) and renders one
// background or window pixel per render item. After reset it runs a clearing pass that zeroes
// both banks, one row of the two banks per cycle; in_stall stays high until it ends, while
// configuration writes are taken as usual (cfg_ready is always high). A write item stores its
// byte at the transfer edge. A render item goes through these steps in order: at the transfer
// edge the tile-map address is issued; in the map state the tile number comes back and the even
// and odd plane bytes of the tile row are read together, one bank each; in the pixel state the
// colour is mapped through the palette into the output register. The output register lets the
// next item transfer while a result still waits; only a new result waits for out_stall to drop.
// Configuration should be written while no render is in flight, since the control byte and
// palette are sampled during the fetch.
module tile_background_pixel_renderer_top
    import tbpr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_IW-1:0]  cfg_index,
    input  logic [7:0]         cfg_data,
    // item input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [VRAM_AW-1:0] mem_address,
    input  logic [7:0]         mem_data,
    input  logic [7:0]         screen_line,
    input  logic [7:0]         screen_column,
    // result output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         grey_level,
    output logic [7:0]         out_line,
    output logic [7:0]         out_column
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MAP  = 3'b010,
        ST_PIX  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    cfg_regs_t cfg;

    // clearing pass
    logic               clearing_reg;
    logic [BANK_AW-1:0] clr_addr_reg;

    // per-item context
    logic [7:0]   line_reg;
    logic [7:0]   col_reg;
    logic [2:0]   fine_x_reg;
    logic [2:0]   fine_y_reg;
    logic         map_odd_reg;

    // output register
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [7:0]   grey_reg;
    logic [7:0]   out_line_reg;
    logic [7:0]   out_col_reg;

    logic         in_xfer;
    logic         wr_xfer;
    logic         rd_xfer;
    logic         out_load;

    // bank ports
    logic               we_even;
    logic               we_odd;
    logic [BANK_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [BANK_AW-1:0] raddr;
    logic [7:0]         rdata_even;
    logic [7:0]         rdata_odd;

    // pixel coordinates and fetch addresses
    logic               use_window;
    logic [8:0]         col_plus7;
    logic [7:0]         pix_x;
    logic [7:0]         pix_y;
    logic               map_hi;
    logic [VRAM_AW-1:0] map_addr;
    logic [7:0]         map_entry;
    logic [8:0]         tile_base;
    logic [BANK_AW-1:0] row_index;
    logic [1:0]         colour;

    assign cfg_ready = 1'b1;

    tbpr_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Take items only while idle and after the clearing pass
    assign in_stall = clearing_reg || (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign wr_xfer  = in_xfer && (cmd == CMD_WRITE);
    assign rd_xfer  = in_xfer && (cmd == CMD_RENDER);

    // Window or scrolled background coordinates, modulo 256
    assign col_plus7  = {1'b0, screen_column} + 9'd7;
    assign use_window = cfg.lcd_control[LCDC_WIN_ON] && (screen_line >= cfg.window_y) &&
                        (col_plus7 >= {1'b0, cfg.window_x});

    always_comb
    begin
        if (use_window)
        begin
            pix_x  = 8'(col_plus7 - {1'b0, cfg.window_x});
            pix_y  = screen_line - cfg.window_y;
            map_hi = cfg.lcd_control[LCDC_WIN_MAP_HI];
        end
        else
        begin
            pix_x  = screen_column + cfg.scroll_x;
            pix_y  = screen_line + cfg.scroll_y;
            map_hi = cfg.lcd_control[LCDC_BG_MAP_HI];
        end
    end

    // Map sits at 0x1800 or 0x1C00: 32 entries per tile row
    assign map_addr = {2'b11, map_hi, pix_y[7:3], pix_x[7:3]};

    // Tile number from whichever bank held the map byte
    assign map_entry = map_odd_reg ? rdata_odd : rdata_even;

    // Unsigned tiles from 0x0000, signed tiles around 0x1000 (16 bytes each)
    always_comb
    begin
        if (cfg.lcd_control[LCDC_TILES_UNS])
        begin
            tile_base = {1'b0, map_entry};
        end
        else
        begin
            tile_base = SIGNED_TILE_BASE + {1'b0, map_entry ^ 8'h80};
        end
    end

    // Tile row pair: even byte is the low plane, odd byte the high plane
    assign row_index = {tile_base, fine_y_reg};

    // Clearing writes win; afterwards a write item stores into its bank
    always_comb
    begin
        if (clearing_reg)
        begin
            we_even = 1'b1;
            we_odd  = 1'b1;
            waddr   = clr_addr_reg;
            wdata   = '0;
        end
        else
        begin
            we_even = wr_xfer && !mem_address[0];
            we_odd  = wr_xfer && mem_address[0];
            waddr   = mem_address[VRAM_AW-1:1];
            wdata   = mem_data;
        end
    end

    // Issue the map read at the transfer, the plane read in the map state; hold otherwise
    assign re    = rd_xfer || (state_reg == ST_MAP);
    assign raddr = (state_reg == ST_MAP) ? row_index : map_addr[VRAM_AW-1:1];

    tbpr_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_bank_even (
        .clk   (clk),
        .we    (we_even),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata_even)
    );

    tbpr_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_bank_odd (
        .clk   (clk),
        .we    (we_odd),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata_odd)
    );

    // Pixel bit 7 - fine x of each plane
    assign colour = {rdata_odd[~fine_x_reg], rdata_even[~fine_x_reg]};

    // Load the output register once it is free or being drained
    assign out_load = (state_reg == ST_PIX) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (rd_xfer) state_next = ST_MAP;
            ST_MAP:  state_next = ST_PIX;
            ST_PIX:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rd_xfer)
        begin
            line_reg    <= screen_line;
            col_reg     <= screen_column;
            fine_x_reg  <= pix_x[2:0];
            fine_y_reg  <= pix_y[2:0];
            map_odd_reg <= map_addr[0];
        end
        if (out_load)
        begin
            grey_reg     <= grey_of(cfg.bg_palette, colour);
            out_line_reg <= line_reg;
            out_col_reg  <= col_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign grey_level = grey_reg;
    assign out_line   = out_line_reg;
    assign out_column = out_col_reg;

    // A render transfer walks through the map fetch and then the plane fetch
    a_render_seq: assert property (@(posedge clk) disable iff (!rst_n)
        rd_xfer |=> (state_reg == ST_MAP) ##1 (state_reg == ST_PIX))
        else $error("render fetch sequence broken");

    // A new result only appears out of the pixel state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_PIX))
        else $error("result appeared without a finished fetch");

    // A finished pixel waits while the output register is stalled
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PIX && out_valid && out_stall) |=> (state_reg == ST_PIX))
        else $error("pixel dropped while output stalled");

    // The clearing pass ends after its last row
    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        (clearing_reg && (&clr_addr_reg)) |=> !clearing_reg)
        else $error("clearing pass overran");

endmodule

### test/tbpr_checker.sv
// Checker for the tile background pixel renderer: watches the channels, predicts pixels, compares.
module tbpr_checker
    import tbpr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CFG_IW-1:0]  cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               cmd,
    input  logic [VRAM_AW-1:0] mem_address,
    input  logic [7:0]         mem_data,
    input  logic [7:0]         screen_line,
    input  logic [7:0]         screen_column,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [7:0]         grey_level,
    input  logic [7:0]         out_line,
    input  logic [7:0]         out_column,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [VRAM_AW-1:0] MAP_LOW_BASE    = 13'h1800;
    localparam logic [VRAM_AW-1:0] MAP_HIGH_BASE   = 13'h1C00;
    localparam logic [VRAM_AW-1:0] SIGNED_TILE_LOW = 13'h0800;

    typedef struct packed {
        logic [7:0] grey;
        logic [7:0] line_no;
        logic [7:0] column_no;
    } pixel_t;

    logic [7:0] vram_copy [0:(1 << VRAM_AW) - 1];
    cfg_regs_t  regs;
    pixel_t     pixels_due [$];

    // Background or window fetch, plane bytes, palette and grey level of one pixel
    function automatic logic [7:0] pixel_grey(input logic [7:0] scan, input logic [7:0] col);
        logic               in_window;
        logic [7:0]         x;
        logic [7:0]         y;
        logic [VRAM_AW-1:0] map_base;
        logic [VRAM_AW-1:0] map_addr;
        logic [VRAM_AW-1:0] tile_addr;
        logic [VRAM_AW-1:0] row_addr;
        logic [7:0]         tile_no;
        logic [7:0]         plane_lo;
        logic [7:0]         plane_hi;
        logic [2:0]         bit_pos;
        logic [1:0]         colour;
        logic [1:0]         shade;
        logic [7:0]         grey;
        in_window = regs.lcd_control[LCDC_WIN_ON] && (scan >= regs.window_y)
                    && ({1'b0, col} + 9'd7 >= {1'b0, regs.window_x});
        if (in_window)
        begin
            x = col + 8'd7 - regs.window_x;
            y = scan - regs.window_y;
            map_base = regs.lcd_control[LCDC_WIN_MAP_HI] ? MAP_HIGH_BASE : MAP_LOW_BASE;
        end
        else
        begin
            x = col + regs.scroll_x;
            y = scan + regs.scroll_y;
            map_base = regs.lcd_control[LCDC_BG_MAP_HI] ? MAP_HIGH_BASE : MAP_LOW_BASE;
        end
        map_addr = map_base + {3'b000, y[7:3], x[7:3]};
        tile_no  = vram_copy[map_addr];
        // signed numbers count from the middle of the tile area
        if (regs.lcd_control[LCDC_TILES_UNS])
            tile_addr = {1'b0, tile_no, 4'h0};
        else
            tile_addr = SIGNED_TILE_LOW + {1'b0, tile_no ^ 8'h80, 4'h0};
        row_addr = tile_addr + {9'd0, y[2:0], 1'b0};
        plane_lo = vram_copy[row_addr];
        plane_hi = vram_copy[row_addr + 13'd1];
        bit_pos  = 3'd7 - x[2:0];
        colour   = {plane_hi[bit_pos], plane_lo[bit_pos]};
        shade    = regs.bg_palette[2 * colour +: 2];
        case (shade)
            2'd0:    grey = GREY_0;
            2'd1:    grey = GREY_1;
            2'd2:    grey = GREY_2;
            default: grey = GREY_3;
        endcase
        return grey;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            regs = '0;
            regs.lcd_control = LCDC_RESET;
            regs.bg_palette  = PALETTE_RESET;
            foreach (vram_copy[i])
                vram_copy[i] = 8'd0;
            pixels_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pixels_due.size() == 0)
                begin
                    $error("pixel with none due: line %0d column %0d grey %0d",
                           out_line, out_column, grey_level);
                    fail_count++;
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (grey_level !== want.grey)
                    begin
                        $error("grey_level: expected %0d, got %0d", want.grey, grey_level);
                        fail_count++;
                    end
                    if (out_line !== want.line_no)
                    begin
                        $error("out_line: expected %0d, got %0d", want.line_no, out_line);
                        fail_count++;
                    end
                    if (out_column !== want.column_no)
                    begin
                        $error("out_column: expected %0d, got %0d", want.column_no, out_column);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LCD_CONTROL: regs.lcd_control = cfg_data;
                    REG_SCROLL_Y:    regs.scroll_y    = cfg_data;
                    REG_SCROLL_X:    regs.scroll_x    = cfg_data;
                    REG_WINDOW_Y:    regs.window_y    = cfg_data;
                    REG_WINDOW_X:    regs.window_x    = cfg_data;
                    REG_BG_PALETTE:  regs.bg_palette  = cfg_data;
                    default:         ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (cmd == CMD_WRITE)
                    vram_copy[mem_address] = mem_data;
                else
                    pixels_due.push_back('{grey: pixel_grey(screen_line, screen_column),
                                           line_no: screen_line, column_no: screen_column});
            end
            pending = pixels_due.size();
        end
    end

endmodule

### test/tb_top.sv
// Testbench top of the tile background pixel renderer: clock, reset, stimulus and verdict.
module tb_top
    import tbpr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES    = 5;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int IDLE_PERCENT    = 35;
    localparam int HOLD_CYCLES     = 400;
    // a render passes the map and pixel states; leave a margin before touching registers
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 20;
    // the clearing pass after reset alone is a long stretch without a transfer
    localparam int WATCHDOG_LIMIT  = 20000;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [CFG_IW-1:0]  cfg_index     = '0;
    logic [7:0]         cfg_data      = '0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic               cmd           = CMD_WRITE;
    logic [VRAM_AW-1:0] mem_address   = '0;
    logic [7:0]         mem_data      = '0;
    logic [7:0]         screen_line   = '0;
    logic [7:0]         screen_column = '0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [7:0]         grey_level;
    logic [7:0]         out_line;
    logic [7:0]         out_column;

    int   fail_count;
    int   pending;
    // steady: no idling on either side; hold_pending: ask the receiver for a long hold-off
    logic steady       = 1'b0;
    logic hold_pending = 1'b0;

    always #6 clk = ~clk;

    tile_background_pixel_renderer_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .mem_address   (mem_address),
        .mem_data      (mem_data),
        .screen_line   (screen_line),
        .screen_column (screen_column),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .grey_level    (grey_level),
        .out_line      (out_line),
        .out_column    (out_column)
    );

    tbpr_checker pixel_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .mem_address   (mem_address),
        .mem_data      (mem_data),
        .screen_line   (screen_line),
        .screen_column (screen_column),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .grey_level    (grey_level),
        .out_line      (out_line),
        .out_column    (out_column),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Offer one item and hold it until the transfer. Valid stays high on return so that
    // back-to-back items keep it asserted; whoever comes next lowers it when needed.
    task automatic push_item(input logic kind, input logic [VRAM_AW-1:0] addr,
                             input logic [7:0] data, input logic [7:0] scan,
                             input logic [7:0] col);
        if (!steady)
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid      <= 1'b1;
        cmd           <= kind;
        mem_address   <= addr;
        mem_data      <= data;
        screen_line   <= scan;
        screen_column <= col;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Fields that the item kind ignores still get random values
    task automatic vram_store(input logic [VRAM_AW-1:0] addr, input logic [7:0] data);
        push_item(CMD_WRITE, addr, data, 8'($urandom), 8'($urandom));
    endtask

    task automatic render_at(input logic [7:0] scan, input logic [7:0] col);
        push_item(CMD_RENDER, VRAM_AW'($urandom), 8'($urandom), scan, col);
    endtask

    // One random item. Writes lean toward the tile maps and the two tiles that an empty map
    // points at, so that renders see varied tiles rather than all-zero memory.
    task automatic random_item(input logic renders_only);
        int                 pick;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         scan;
        logic [7:0]         col;
        if (renders_only || $urandom_range(99) < 55)
        begin
            // mostly on screen, sometimes off the edge
            scan = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(143));
            col  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(159));
            render_at(scan, col);
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                addr = 13'h1800 + VRAM_AW'($urandom_range(13'h7FF));
            else if (pick < 45)
                addr = VRAM_AW'($urandom_range(15));
            else if (pick < 60)
                addr = 13'h1000 + VRAM_AW'($urandom_range(15));
            else
                addr = VRAM_AW'($urandom);
            vram_store(addr, 8'($urandom));
        end
    endtask

    // Drop valid, wait until every pixel has come back, then let the pipeline go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Write all six registers plus the two unused indexes, valid held high throughout
    task automatic write_config(input cfg_regs_t setting);
        logic [CFG_IW-1:0] idx;
        logic [7:0]        value;
        for (int i = 0; i < (1 << CFG_IW); i++)
        begin
            idx = CFG_IW'(i);
            case (idx)
                REG_LCD_CONTROL: value = setting.lcd_control;
                REG_SCROLL_Y:    value = setting.scroll_y;
                REG_SCROLL_X:    value = setting.scroll_x;
                REG_WINDOW_Y:    value = setting.window_y;
                REG_WINDOW_X:    value = setting.window_x;
                REG_BG_PALETTE:  value = setting.bg_palette;
                default:         value = 8'($urandom);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stall, a stall-free stretch when steady, and a long counted hold-off
    // once one is requested. Exactly one assignment to out_stall per clock edge.
    initial
    begin
        int   hold_left;
        logic hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (steady)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Watchdog: count edges without any item or pixel transfer
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus
    initial
    begin
        cfg_regs_t setting;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset registers: unsigned tiles, low background map, window
        // off. Map entry 0 points at tile 1, entry 1 at tile 0x80; fill their first rows, hit
        // both ends of memory with both extreme bytes, then render across those tiles and at
        // the corners of the screen and of the field range.
        vram_store(13'h1800, 8'h01);
        vram_store(13'h1801, 8'h80);
        vram_store(13'h0010, 8'h3C);
        vram_store(13'h0011, 8'hC3);
        vram_store(13'h0800, 8'h99);
        vram_store(13'h0801, 8'h66);
        vram_store(13'h1FFF, 8'hFF);
        vram_store(13'h0000, 8'h00);
        vram_store(13'h1000, 8'hA5);
        render_at(8'd0, 8'd0);
        render_at(8'd0, 8'd3);
        render_at(8'd0, 8'd6);
        render_at(8'd0, 8'd7);
        render_at(8'd0, 8'd8);
        render_at(8'd0, 8'd12);
        render_at(8'd0, 8'd15);
        render_at(8'd7, 8'd0);
        render_at(8'd8, 8'd0);
        render_at(8'd143, 8'd159);
        render_at(8'd0, 8'd255);
        render_at(8'd255, 8'd0);
        render_at(8'd255, 8'd255);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // registers change only with nothing in flight
            settle();
            setting.lcd_control = 8'($urandom);
            setting.scroll_y    = 8'($urandom);
            setting.scroll_x    = 8'($urandom);
            setting.window_y    = 8'($urandom_range(150));
            setting.window_x    = 8'($urandom_range(170));
            setting.bg_palette  = 8'($urandom);
            if ($urandom_range(3) != 0)
                setting.lcd_control[LCDC_WIN_ON] = 1'b1;
            case (phase)
                0: setting = '0;
                1: setting = '1;
                2:
                begin
                    // window left of column zero: shifted left by seven minus its x
                    setting.lcd_control[LCDC_WIN_ON] = 1'b1;
                    setting.window_y  = 8'd0;
                    setting.window_x  = 8'($urandom_range(6));
                    setting.bg_palette = 8'hE4;
                end
                3:
                begin
                    // window edges at the last line and the last column
                    setting.lcd_control[LCDC_WIN_ON] = 1'b1;
                    setting.window_y = 8'd143;
                    setting.window_x = 8'd166;
                end
                4: setting.window_x = 8'd255;
                default: ;
            endcase
            write_config(setting);

            // one stretch with no idling, one long receiver hold-off that holds back a run of renders
            steady = (phase == 6);
            if (phase == 5)
                hold_pending = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                random_item(phase == 5);
        end

        // Drain and wait out the pipeline before the verdict
        steady = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### tile_background_pixel_renderer_top.f
sv/tbpr_pkg.sv
sv/tbpr_ram.sv
sv/tbpr_cfg_regs.sv
sv/tile_background_pixel_renderer_top.sv
test/tbpr_checker.sv
test/tb_top.sv
